### design/wft_pkg.sv
package wft_pkg;

  // Fixed block dimensions.
  localparam int MotorCount = 4;
  localparam int MotorIdxW  = 2;
  localparam int WordW      = 16;
  localparam int MagW       = WordW + 1;
  localparam int ScaleW     = 20;
  localparam int ProdW      = MagW + ScaleW;
  localparam int FracW      = 20;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 20;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  // Register reset values.
  localparam logic [10:0] BaseIdReset     = 11'd150;
  localparam logic [15:0] StaleLimitReset = 16'd200;
  localparam logic [3:0]  ReverseReset    = 4'b1010;
  localparam logic [19:0] ScaleReset      = 20'd82355;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ID     = 2'd0,
    CFG_STALE_LIMIT = 2'd1,
    CFG_REVERSE     = 2'd2,
    CFG_SCALE       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] base_id;
    logic [15:0] stale_limit;
    logic [3:0]  reverse_mask;
    logic [19:0] speed_scale;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic        is_extended;
    logic [3:0]  frame_length;
    logic [15:0] speed_word;
    logic [7:0]  fault_byte;
  } in_t;

  typedef struct packed {
    logic               frame_taken;
    logic [3:0]         fresh_mask;
    logic               all_fresh;
    logic [31:0]        newest_time_ms;
    logic [7:0]         first_fault;
    logic [1:0]         left_count;
    logic [1:0]         right_count;
    logic signed [15:0] left_mean_speed;
    logic signed [15:0] right_mean_speed;
  } out_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic                 taken;
    logic [MotorIdxW-1:0] motor;
    logic [31:0]          now_ms;
    logic [7:0]           fault;
    logic                 neg;
    logic [ProdW-1:0]     prod;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

endpackage

### design/wft_front.sv
module wft_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wft_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wft_pkg::in_t  in_req_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output wft_pkg::req_t q_req_o
);
  import wft_pkg::*;

  logic                 hold_valid_q, hold_valid_d;
  in_t                  hold_q;
  logic                 accept, push;
  logic [11:0]          id_off;
  logic [MotorIdxW-1:0] motor;
  logic                 reversed, word_neg, word_nz;
  logic [MagW-1:0]      mag;

  // Handshake of the holding register.
  assign push         = hold_valid_q && q_ready_i;
  assign in_stall_o   = hold_valid_q && !q_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign hold_valid_d = accept || (hold_valid_q && !push);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= in_req_i;
    end
  end

  // Offset of the id above motor one's id; a valid motor leaves only the low two bits.
  assign id_off   = {1'b0, hold_q.frame_id} - {1'b0, cfg_i.base_id} - 12'd1;
  assign motor    = id_off[MotorIdxW-1:0];
  assign reversed = cfg_i.reverse_mask[motor];
  assign word_neg = hold_q.speed_word[WordW-1];
  assign word_nz  = |hold_q.speed_word;

  // Magnitude of the signed word; the sign is tracked separately.
  assign mag = word_neg ? (MagW'(0) - {1'b1, hold_q.speed_word})
                        : {1'b0, hold_q.speed_word};

  // Classify the request and start the speed scaling.
  always_comb begin
    q_req_o.taken  = !hold_q.action && !hold_q.is_extended && hold_q.frame_length[3]
                     && (id_off[11:MotorIdxW] == '0);
    q_req_o.motor  = motor;
    q_req_o.now_ms = hold_q.now_ms;
    q_req_o.fault  = hold_q.fault_byte;
    q_req_o.neg    = reversed ? (!word_neg && word_nz) : word_neg;
    q_req_o.prod   = {{ScaleW{1'b0}}, mag} * {{MagW{1'b0}}, cfg_i.speed_scale};
  end

  assign q_valid_o = hold_valid_q;

endmodule

### design/wft_queue.sv
module wft_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  wft_pkg::req_t push_req_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output wft_pkg::req_t pop_req_o
);
  import wft_pkg::*;

  req_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

### design/wft_back.sv
module wft_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wft_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  wft_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wft_pkg::out_t out_res_o
);
  import wft_pkg::*;

  localparam logic [MotorIdxW-1:0] LastIdx = MotorIdxW'(MotorCount - 1);

  back_state_e          state_q, state_d;
  logic [MotorIdxW-1:0] idx_q;
  logic                 pop, scan_step, load_out, slot_free;

  // Motor entries.
  logic        entry_valid_q [MotorCount];
  logic [31:0] entry_time_q  [MotorCount];
  logic [7:0]  entry_fault_q [MotorCount];
  logic [15:0] entry_speed_q [MotorCount];

  // Per-request working registers.
  logic               taken_q;
  logic [31:0]        now_q;
  logic [3:0]         mask_q;
  logic [31:0]        newest_q;
  logic [7:0]         first_q;
  logic [1:0]         lcnt_q, rcnt_q;
  logic signed [16:0] lsum_q, rsum_q;

  logic               out_valid_q;
  out_t               out_q;

  logic [ProdW:0]     rnd_sum;
  logic [17:0]        rnd;
  logic [15:0]        speed_res;
  logic [31:0]        age;
  logic               fresh, left_side;
  logic signed [16:0] cur_speed;
  logic signed [15:0] lavg, ravg;

  // Round half away from zero and saturate the scaled speed.
  assign rnd_sum = {1'b0, q_req_i.prod} + ((ProdW + 1)'(1) << (FracW - 1));
  assign rnd     = rnd_sum[ProdW:FracW];
  always_comb begin
    if (q_req_i.neg) begin
      speed_res = (rnd > 18'd32768) ? 16'h8000 : (16'd0 - rnd[15:0]);
    end else begin
      speed_res = (rnd > 18'd32767) ? 16'h7FFF : rnd[15:0];
    end
  end

  assign q_ready_o = (state_q == BK_IDLE);
  assign pop       = q_valid_i && q_ready_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Sequencer: take a request, scan the four entries, then hand off the result.
  always_comb begin
    state_d   = state_q;
    scan_step = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (pop) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        scan_step = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        idx_q <= '0;
      end else if (scan_step) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Entry update when a frame is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MotorCount; i++) begin
        entry_valid_q[i] <= 1'b0;
      end
    end else if (pop && q_req_i.taken) begin
      entry_valid_q[q_req_i.motor] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_req_i.taken) begin
      entry_time_q[q_req_i.motor]  <= q_req_i.now_ms;
      entry_fault_q[q_req_i.motor] <= q_req_i.fault;
      entry_speed_q[q_req_i.motor] <= speed_res;
    end
  end

  // Freshness of the entry under scan.
  assign age       = now_q - entry_time_q[idx_q];
  assign fresh     = entry_valid_q[idx_q] && (age <= {16'd0, cfg_i.stale_limit});
  assign left_side = !idx_q[0];
  assign cur_speed = 17'(signed'(entry_speed_q[idx_q]));

  // Accumulate the aggregate one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      taken_q  <= q_req_i.taken;
      now_q    <= q_req_i.now_ms;
      mask_q   <= '0;
      newest_q <= '0;
      first_q  <= '0;
      lcnt_q   <= '0;
      rcnt_q   <= '0;
      lsum_q   <= '0;
      rsum_q   <= '0;
    end else if (scan_step && fresh) begin
      mask_q[idx_q] <= 1'b1;
      if (entry_time_q[idx_q] > newest_q) begin
        newest_q <= entry_time_q[idx_q];
      end
      if (first_q == '0) begin
        first_q <= entry_fault_q[idx_q];
      end
      if (left_side) begin
        lcnt_q <= lcnt_q + 1'b1;
        lsum_q <= lsum_q + cur_speed;
      end else begin
        rcnt_q <= rcnt_q + 1'b1;
        rsum_q <= rsum_q + cur_speed;
      end
    end
  end

  // Mean of at most two speeds, truncated toward zero.
  function automatic logic signed [15:0] side_avg(logic [1:0] cnt, logic signed [16:0] sum);
    logic signed [16:0] adj;
    adj = sum + 17'(sum[16]);
    if (cnt == 2'd2) begin
      return 16'(adj >>> 1);
    end else if (cnt == 2'd1) begin
      return sum[15:0];
    end else begin
      return 16'sd0;
    end
  endfunction

  assign lavg = side_avg(lcnt_q, lsum_q);
  assign ravg = side_avg(rcnt_q, rsum_q);

  // Output register decouples the result from the downstream stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.frame_taken      <= taken_q;
      out_q.fresh_mask       <= mask_q;
      out_q.all_fresh        <= (mask_q == 4'hF);
      out_q.newest_time_ms   <= newest_q;
      out_q.first_fault      <= first_q;
      out_q.left_count       <= lcnt_q;
      out_q.right_count      <= rcnt_q;
      out_q.left_mean_speed  <= lavg;
      out_q.right_mean_speed <= ravg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // The per-side counts add up to the fresh motors.
  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(out_q.fresh_mask) ==
                     int'(out_q.left_count) + int'(out_q.right_count)))
    else $error("side counts disagree with fresh mask");

  // With nothing fresh, the aggregate is all zero.
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fresh_mask == 4'h0) |->
      (out_q.newest_time_ms == '0 && out_q.first_fault == '0 &&
       out_q.left_mean_speed == '0 && out_q.right_mean_speed == '0))
    else $error("nonzero aggregate with no fresh entry");

  // The scan visits every entry before the result is formed.
  a_scan_runs_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN && idx_q != LastIdx) |=> (state_q == BK_SCAN))
    else $error("scan left early");

  // No new request is taken while a result is still being formed.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN || state_q == BK_DONE) |-> !pop)
    else $error("request popped while busy");

endmodule

### design/wheel_feedback_freshness_tracker.sv
// Path: a request is accepted into the front end's holding register, passes through the queue
// and is popped by the back end, which updates the entry, scans the four entries and then loads
// the output register; the back end takes no new request until that result has been loaded.
// Reset clears all motor entries to invalid and loads the configuration register defaults.
// Configuration writes are taken every cycle.
module wheel_feedback_freshness_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wft_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wft_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wft_pkg::in_t                        in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wft_pkg::out_t                       out_res_o
);
  import wft_pkg::*;

  cfg_t cfg_q;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  req_t q_push_req, q_pop_req;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_id      <= BaseIdReset;
      cfg_q.stale_limit  <= StaleLimitReset;
      cfg_q.reverse_mask <= ReverseReset;
      cfg_q.speed_scale  <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE_ID:     cfg_q.base_id      <= cfg_data_i[10:0];
        CFG_STALE_LIMIT: cfg_q.stale_limit  <= cfg_data_i[15:0];
        CFG_REVERSE:     cfg_q.reverse_mask <= cfg_data_i[3:0];
        CFG_SCALE:       cfg_q.speed_scale  <= cfg_data_i[19:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts and classifies requests.
  wft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_push_valid),
    .q_ready_i  (q_push_ready),
    .q_req_o    (q_push_req)
  );

  // Queue between front and back.
  wft_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_req_i   (q_push_req),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_req_o    (q_pop_req)
  );

  // Back end: updates entries and forms the aggregate.
  wft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_pop_valid),
    .q_ready_o   (q_pop_ready),
    .q_req_i     (q_pop_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

### verif/wft_freshness_checker.sv
// Watches the configuration, request and result channels of the wheel feedback
// freshness tracker. Tracks its own copy of the motor entries and registers,
// predicts the summary for every accepted request and compares each accepted
// result against the oldest outstanding prediction.
module wft_freshness_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [wft_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wft_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  wft_pkg::in_t                 in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  wft_pkg::out_t                out_res_i,
  output int                           awaiting_o,
  output int                           mismatches_o
);
  import wft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  logic [10:0] base_id;
  logic [15:0] stale_limit;
  logic [3:0]  reverse_mask;
  logic [19:0] speed_scale;

  // Motor entry copies.
  logic               motor_live  [MotorCount];
  logic [31:0]        motor_rx_ms [MotorCount];
  logic [7:0]         motor_fault [MotorCount];
  logic signed [15:0] motor_mmps  [MotorCount];

  out_t summaries_due[$];
  out_t oldest;
  int   results_seen;
  int   mismatches;

  assign mismatches_o = mismatches;

  task automatic note_mismatch(string what, longint got, longint want);
    $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
             got, want);
    mismatches++;
  endtask

  // Scales a raw speed word to mm/s, rounding half away from zero and saturating.
  function automatic logic signed [15:0] wheel_mmps(logic [15:0] word, logic reversed);
    longint raw;
    longint mag;
    longint rounded;
    raw = longint'($signed(word));
    if (reversed) begin
      raw = -raw;
    end
    mag = (raw < 0) ? -raw : raw;
    rounded = (mag * longint'(speed_scale) + (longint'(1) << 19)) >>> 20;
    if (raw < 0) begin
      if (rounded > 32768) begin
        rounded = 32768;
      end
      return 16'(-rounded);
    end
    if (rounded > 32767) begin
      rounded = 32767;
    end
    return 16'(rounded);
  endfunction

  // Applies one request to the entries and builds the summary over fresh motors.
  function automatic out_t track_request(in_t req);
    out_t        res;
    logic [11:0] offset;
    logic [31:0] age;
    int          slot;
    int          m;
    int          lsum;
    int          rsum;
    res    = '0;
    lsum   = 0;
    rsum   = 0;
    offset = {1'b0, req.frame_id} - {1'b0, base_id};
    if (!req.action && !req.is_extended && req.frame_length >= 4'd8 &&
        offset >= 12'd1 && offset <= 12'(MotorCount)) begin
      slot = int'(offset) - 1;
      motor_live[slot]  = 1'b1;
      motor_rx_ms[slot] = req.now_ms;
      motor_fault[slot] = req.fault_byte;
      motor_mmps[slot]  = wheel_mmps(req.speed_word, reverse_mask[slot]);
      res.frame_taken   = 1'b1;
    end
    for (m = 0; m < MotorCount; m++) begin
      age = req.now_ms - motor_rx_ms[m];
      if (motor_live[m] && age <= {16'd0, stale_limit}) begin
        res.fresh_mask[m] = 1'b1;
        if (motor_rx_ms[m] > res.newest_time_ms) begin
          res.newest_time_ms = motor_rx_ms[m];
        end
        if (res.first_fault == 8'd0) begin
          res.first_fault = motor_fault[m];
        end
        // Motors one and three are on the left, two and four on the right.
        if (m % 2 == 0) begin
          lsum += motor_mmps[m];
          res.left_count += 2'd1;
        end else begin
          rsum += motor_mmps[m];
          res.right_count += 2'd1;
        end
      end
    end
    res.all_fresh = &res.fresh_mask;
    if (res.left_count != 2'd0) begin
      res.left_mean_speed = 16'(lsum / int'(res.left_count));
    end
    if (res.right_count != 2'd0) begin
      res.right_mean_speed = 16'(rsum / int'(res.right_count));
    end
    return res;
  endfunction

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id      = BaseIdReset;
      stale_limit  = StaleLimitReset;
      reverse_mask = ReverseReset;
      speed_scale  = ScaleReset;
      for (int k = 0; k < MotorCount; k++) begin
        motor_live[k]  = 1'b0;
        motor_rx_ms[k] = '0;
        motor_fault[k] = '0;
        motor_mmps[k]  = '0;
      end
      summaries_due.delete();
      awaiting_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (summaries_due.size() == 0) begin
          note_mismatch("unexpected result, fresh_mask", longint'(out_res_i.fresh_mask), 0);
        end else begin
          oldest = summaries_due.pop_front();
          if (out_res_i.frame_taken !== oldest.frame_taken)
            note_mismatch("frame_taken", longint'(out_res_i.frame_taken),
                          longint'(oldest.frame_taken));
          if (out_res_i.fresh_mask !== oldest.fresh_mask)
            note_mismatch("fresh_mask", longint'(out_res_i.fresh_mask),
                          longint'(oldest.fresh_mask));
          if (out_res_i.all_fresh !== oldest.all_fresh)
            note_mismatch("all_fresh", longint'(out_res_i.all_fresh),
                          longint'(oldest.all_fresh));
          if (out_res_i.newest_time_ms !== oldest.newest_time_ms)
            note_mismatch("newest_time_ms", longint'(out_res_i.newest_time_ms),
                          longint'(oldest.newest_time_ms));
          if (out_res_i.first_fault !== oldest.first_fault)
            note_mismatch("first_fault", longint'(out_res_i.first_fault),
                          longint'(oldest.first_fault));
          if (out_res_i.left_count !== oldest.left_count)
            note_mismatch("left_count", longint'(out_res_i.left_count),
                          longint'(oldest.left_count));
          if (out_res_i.right_count !== oldest.right_count)
            note_mismatch("right_count", longint'(out_res_i.right_count),
                          longint'(oldest.right_count));
          if (out_res_i.left_mean_speed !== oldest.left_mean_speed)
            note_mismatch("left_mean_speed", longint'(out_res_i.left_mean_speed),
                          longint'(oldest.left_mean_speed));
          if (out_res_i.right_mean_speed !== oldest.right_mean_speed)
            note_mismatch("right_mean_speed", longint'(out_res_i.right_mean_speed),
                          longint'(oldest.right_mean_speed));
        end
        results_seen++;
      end

      // Register writes are expected only while nothing is in flight; the checker does not enforce it.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BASE_ID:     base_id      = cfg_data_i[10:0];
          CFG_STALE_LIMIT: stale_limit  = cfg_data_i[15:0];
          CFG_REVERSE:     reverse_mask = cfg_data_i[3:0];
          CFG_SCALE:       speed_scale  = cfg_data_i[19:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        summaries_due.push_back(track_request(in_req_i));
      end
      awaiting_o <= summaries_due.size();
    end
  end

endmodule

### verif/wheel_feedback_freshness_tracker_tb.sv
// Drives requests and register writes into the freshness tracker, throttles the
// result side, and reports the verdict from the checker's mismatch count.
module wheel_feedback_freshness_tracker_tb;
  import wft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_res_o;

  int          awaiting;
  int          mismatch_total;
  bit          calm;
  bit          hold_off_req;
  logic [31:0] wall_ms;
  logic [10:0] cur_base;
  logic [15:0] cur_stale;

  wheel_feedback_freshness_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  wft_freshness_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_i    (out_res_o),
    .awaiting_o   (awaiting),
    .mismatches_o (mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[wheel_feedback_freshness_tracker] ERROR");
    $finish;
  end

  // Result side: short random stalls, or one long hold-off when asked for.
  initial begin
    int held;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < 80; held++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // Presents a request and returns once it is taken; valid stays high.
  task automatic offer_req(in_t req);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic rest_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted summary has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [10:0] base, logic [15:0] stale, logic [3:0] rev,
                              logic [19:0] scale);
    put_reg(CFG_BASE_ID, CfgDataW'(base));
    put_reg(CFG_STALE_LIMIT, CfgDataW'(stale));
    put_reg(CFG_REVERSE, CfgDataW'(rev));
    put_reg(CFG_SCALE, scale);
    cfg_valid_i <= 1'b0;
    cur_base  = base;
    cur_stale = stale;
  endtask

  function automatic in_t frame_req(logic [31:0] now, logic [10:0] id, logic [3:0] len,
                                    logic [15:0] word, logic [7:0] fault);
    in_t req;
    req              = '0;
    req.now_ms       = now;
    req.frame_id     = id;
    req.frame_length = len;
    req.speed_word   = word;
    req.fault_byte   = fault;
    return req;
  endfunction

  // Random requests: mostly well-formed feedback frames, mixed with queries and noise.
  task automatic run_phase(int count, bit squeeze);
    in_t         req;
    int unsigned pick;
    int          k;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) wall_ms += $urandom_range(0, cur_stale / 4 + 2);
      else if (pick < 80) wall_ms += $urandom_range(0, cur_stale + cur_stale / 4 + 4);
      else if (pick < 90) wall_ms += $urandom_range(0, 200000);
      else if (pick < 95) wall_ms = $urandom();
      else wall_ms -= $urandom_range(1, 50);

      req            = '0;
      req.now_ms     = wall_ms;
      req.speed_word = 16'($urandom());
      req.fault_byte = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'd0;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        req.frame_length = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
        req.frame_id     = cur_base + 11'($urandom_range(1, 4));
      end else if (pick < 80) begin
        req.action       = 1'b1;
        req.frame_id     = 11'($urandom());
        req.is_extended  = 1'($urandom());
        req.frame_length = 4'($urandom());
      end else begin
        // Near misses around the feedback id window, or anything at all.
        req.frame_id     = ($urandom_range(0, 1) == 0) ?
                           cur_base + 11'($urandom_range(0, 5)) : 11'($urandom());
        req.is_extended  = 1'($urandom());
        req.frame_length = 4'($urandom());
      end

      if (squeeze && k == 10) hold_off_req = 1'b1;
      if (squeeze && k == count / 2) settle();
      offer_req(req);
      if (!calm && $urandom_range(0, 3) == 0) rest_sender($urandom_range(1, 4));
    end
  endtask

  initial begin
    in_t req;
    int  p;
    cur_base  = BaseIdReset;
    cur_stale = StaleLimitReset;
    wall_ms   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: base 150, limit 200, motors two and four reversed.
    req = frame_req(32'd0, 11'd151, 4'd8, 16'h1234, 8'd3);
    req.action = 1'b1;
    offer_req(req);
    offer_req(frame_req(32'd1000, 11'd151, 4'd8, 16'h7FFF, 8'h00));
    offer_req(frame_req(32'd1000, 11'd152, 4'd15, 16'h8000, 8'h55));
    offer_req(frame_req(32'd1010, 11'd153, 4'd9, 16'hFFFF, 8'hFF));
    offer_req(frame_req(32'd1020, 11'd154, 4'd8, 16'h0001, 8'h01));
    // Extended, short and out-of-window frames change nothing.
    req = frame_req(32'd1030, 11'd151, 4'd8, 16'h0000, 8'h77);
    req.is_extended = 1'b1;
    offer_req(req);
    offer_req(frame_req(32'd1030, 11'd152, 4'd7, 16'h4000, 8'h66));
    offer_req(frame_req(32'd1030, 11'd153, 4'd0, 16'h4000, 8'h66));
    offer_req(frame_req(32'd1030, 11'd150, 4'd8, 16'h4000, 8'h66));
    offer_req(frame_req(32'd1030, 11'd155, 4'd8, 16'h4000, 8'h66));
    // Ages exactly at the limit, one past it, and time running backward.
    req = frame_req(32'd1200, 11'd152, 4'd8, 16'h2222, 8'h11);
    req.action = 1'b1;
    offer_req(req);
    req.now_ms = 32'd1201;
    offer_req(req);
    req.now_ms = 32'd999;
    offer_req(req);
    // Entry written just before the time counter wraps, queried just after.
    offer_req(frame_req(32'hFFFF_FFF0, 11'd151, 4'd8, 16'hFF00, 8'h00));
    req.now_ms = 32'h0000_0010;
    offer_req(req);

    settle();
    program_regs(11'd2043, 16'd0, 4'hF, 20'hFFFFF);
    offer_req(frame_req(32'd5, 11'd2044, 4'd8, 16'h8000, 8'h00));
    offer_req(frame_req(32'd5, 11'd2045, 4'd8, 16'h7FFF, 8'h00));
    offer_req(frame_req(32'd5, 11'd2046, 4'd8, 16'h8001, 8'h80));
    offer_req(frame_req(32'd5, 11'd2047, 4'd8, 16'h0000, 8'h10));
    req = frame_req(32'd6, 11'd0, 4'd0, 16'h0000, 8'h00);
    req.action = 1'b1;
    offer_req(req);

    settle();
    program_regs(11'd0, 16'hFFFF, 4'h0, 20'd0);
    offer_req(frame_req(32'd7, 11'd0, 4'd8, 16'h1111, 8'h22));
    offer_req(frame_req(32'd7, 11'd1, 4'd8, 16'hABCD, 8'h00));
    req.now_ms = 32'd7 + 32'd65535;
    offer_req(req);
    req.now_ms = 32'd7 + 32'd65536;
    offer_req(req);

    // Random phases, each under its own register settings.
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_regs(BaseIdReset, StaleLimitReset, ReverseReset, ScaleReset);
        1: program_regs(11'd2043, 16'hFFFF, 4'($urandom()), 20'hFFFFF);
        2: program_regs(11'd0, 16'd0, 4'($urandom()), 20'($urandom()));
        3: begin
          wall_ms = 32'hFFFF_0000;
          program_regs(11'($urandom_range(0, 2043)), 16'($urandom_range(1, 1000)),
                       4'($urandom()), 20'($urandom()));
        end
        default: begin
          calm = (p == 5);
          program_regs(11'($urandom_range(0, 2043)), 16'($urandom()), 4'($urandom()),
                       20'($urandom()));
        end
      endcase
      run_phase(200, p == 0 || p == 3);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_total == 0 && awaiting == 0) begin
      $display("[wheel_feedback_freshness_tracker] OK");
    end else begin
      $display("[wheel_feedback_freshness_tracker] ERROR");
    end
    $finish;
  end

endmodule
